/* src/jan_pkg.sv */
// ----------------------------------------------------------------------------
// jan_pkg
// Shared constants and types for the joystick axis normalizer.
// ----------------------------------------------------------------------------
package jan_pkg;

    // default converter sample width
    localparam int SAMPLE_BITS_DEF = 10;

    // number of axes, one lane each
    localparam int NUM_AXES = 3;

    // full-scale output magnitude and its shift
    localparam int FULL_SCALE  = 128;
    localparam int SCALE_SHIFT = 7;

    // normalized axis width, signed, holds -128..128
    localparam int OUT_W = 9;

    // configuration register index
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OFFSET_X = 3'd0;
    localparam t_cfg_idx CFG_OFFSET_Y = 3'd1;
    localparam t_cfg_idx CFG_OFFSET_Z = 3'd2;
    localparam t_cfg_idx CFG_SPAN_X   = 3'd3;
    localparam t_cfg_idx CFG_SPAN_Y   = 3'd4;
    localparam t_cfg_idx CFG_SPAN_Z   = 3'd5;

endpackage

/* src/jan_lane.sv */
// ----------------------------------------------------------------------------
// jan_lane
// One axis: offset removal, restoring divide of diff*128 by the side span,
// one quotient bit per cycle, then saturation and clamp to -128..128.
// ----------------------------------------------------------------------------
module jan_lane
    import jan_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [SAMPLE_BITS-1:0]       i_raw,
    input  logic [SAMPLE_BITS-1:0]       i_offset,
    input  logic [2*SAMPLE_BITS-1:0]     i_span,
    output logic                         o_busy,
    output logic signed [OUT_W-1:0]      o_axis
);

    localparam int NW = SAMPLE_BITS + SCALE_SHIFT;
    localparam int CW = $clog2(NW + 1);

    logic                     r_busy;
    logic [CW-1:0]            r_cnt;
    logic [NW-1:0]            r_nq;
    logic [SAMPLE_BITS-1:0]   r_rem;
    logic [SAMPLE_BITS-1:0]   r_div;
    logic                     r_neg;
    logic                     r_zero;
    logic                     r_sat;

    logic signed [SAMPLE_BITS:0] w_diff;
    logic                        w_neg;
    logic [SAMPLE_BITS-1:0]      w_mag;
    logic [SAMPLE_BITS-1:0]      w_div;
    logic [SAMPLE_BITS:0]        w_rem_sh;
    logic [SAMPLE_BITS:0]        w_rem_sub;
    logic                        w_ge;
    logic [SAMPLE_BITS-1:0]      n_rem;
    logic                        w_big;
    logic [OUT_W-1:0]            w_qmag;

    // signed difference and side selection
    assign w_diff = $signed({1'b0, i_raw}) - $signed({1'b0, i_offset});
    assign w_neg  = w_diff[SAMPLE_BITS];
    assign w_mag  = w_neg ? SAMPLE_BITS'(-w_diff) : w_diff[SAMPLE_BITS-1:0];
    assign w_div  = w_neg ? i_span[2*SAMPLE_BITS-1:SAMPLE_BITS]
                          : i_span[SAMPLE_BITS-1:0];

    // one restoring step
    assign w_rem_sh  = {r_rem, r_nq[NW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};
    assign n_rem     = w_ge ? w_rem_sub[SAMPLE_BITS-1:0] : w_rem_sh[SAMPLE_BITS-1:0];

    // divider sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq   <= {w_mag, SCALE_SHIFT'(0)};
            r_rem  <= '0;
            r_div  <= w_div;
            r_neg  <= w_neg;
            r_zero <= (w_diff == '0);
            r_sat  <= (w_div == '0);
        end else if (r_busy) begin
            r_nq  <= {r_nq[NW-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    // clamp and sign
    assign w_big = (r_nq > NW'(FULL_SCALE));

    always_comb begin
        if (r_zero) begin
            w_qmag = '0;
        end else if (r_sat || w_big) begin
            w_qmag = OUT_W'(FULL_SCALE);
        end else begin
            w_qmag = r_nq[OUT_W-1:0];
        end
    end

    assign o_axis = r_neg ? -$signed(w_qmag) : $signed(w_qmag);
    assign o_busy = r_busy;

endmodule

/* src/jan_debounce.sv */
// ----------------------------------------------------------------------------
// jan_debounce
// Two-sample button debounce on tick items and one-shot press detection.
// ----------------------------------------------------------------------------
module jan_debounce
    import jan_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_update,
    input  logic i_pin,
    input  logic i_tick,
    output logic o_pressed
);

    logic r_prev_pin;
    logic r_level;
    logic r_latch;
    logic r_pressed;

    logic n_level;

    // level follows the pin when two ticked samples agree, pin low is pressed
    assign n_level = (i_tick && (i_pin == r_prev_pin)) ? ~i_pin : r_level;

    // state update once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pin <= 1'b1;
            r_level    <= 1'b0;
            r_latch    <= 1'b0;
            r_pressed  <= 1'b0;
        end else if (i_update) begin
            if (i_tick) begin
                r_prev_pin <= i_pin;
            end
            r_level   <= n_level;
            r_latch   <= n_level;
            r_pressed <= n_level & ~r_latch;
        end
    end

    assign o_pressed = r_pressed;

endmodule

/* src/joystick_axis_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// joystick_axis_normalizer_unit
// Three-axis joystick normalizer with button debounce, one lane per axis.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (i_in_valid/o_in_ready) takes one sample of three axes,
//    the button pin and the debounce tick; output channel
//    (o_out_valid/i_out_ready) returns the three normalized axes and the
//    one-shot button press, one result per request, in order
//  - the cfg channel writes offsets and spans; o_cfg_ready is always high,
//    writes are expected only while the unit is idle
//  - each lane runs a restoring divider with one quotient bit per cycle over
//    SAMPLE_BITS+7 bits; all three lanes run in parallel
//  - the lanes take one request at a time; o_in_ready returns once the
//    result is loaded into the output register, even while it still waits
//  - reset (synchronous, active low) loads offsets to mid-scale, both spans
//    to half-scale, clears the debounce state and drops o_out_valid
//  - a stalled receiver holds the result; a finished request then waits in
//    the lanes until the output register frees
// ----------------------------------------------------------------------------
module joystick_axis_normalizer_unit
    import jan_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [2*SAMPLE_BITS-1:0]      i_cfg_data,
    // input requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [SAMPLE_BITS-1:0]        i_raw_x,
    input  logic [SAMPLE_BITS-1:0]        i_raw_y,
    input  logic [SAMPLE_BITS-1:0]        i_raw_z,
    input  logic                          i_button_pin,
    input  logic                          i_debounce_tick,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [OUT_W-1:0]       o_axis_x,
    output logic signed [OUT_W-1:0]       o_axis_y,
    output logic signed [OUT_W-1:0]       o_axis_z,
    output logic                          o_button_pressed
);

    localparam logic [SAMPLE_BITS-1:0] OFFSET_RST =
        SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [2*SAMPLE_BITS-1:0] SPAN_RST = {OFFSET_RST, OFFSET_RST};

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_axis [NUM_AXES];
    logic                        r_pressed;
    logic [SAMPLE_BITS-1:0]      r_offset [NUM_AXES];
    logic [2*SAMPLE_BITS-1:0]    r_span [NUM_AXES];

    logic                        w_accept;
    logic                        w_cfg_we;
    logic                        w_lanes_busy;
    logic                        w_load;
    logic [SAMPLE_BITS-1:0]      w_raw [NUM_AXES];
    logic [NUM_AXES-1:0]         w_busy;
    logic signed [OUT_W-1:0]     w_axis [NUM_AXES];
    logic                        w_pressed;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_raw[0] = i_raw_x;
    assign w_raw[1] = i_raw_y;
    assign w_raw[2] = i_raw_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_offset[a] <= OFFSET_RST;
                r_span[a]   <= SPAN_RST;
            end
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET_X: r_offset[0] <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_OFFSET_Y: r_offset[1] <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_OFFSET_Z: r_offset[2] <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_SPAN_X:   r_span[0]   <= i_cfg_data;
                CFG_SPAN_Y:   r_span[1]   <= i_cfg_data;
                CFG_SPAN_Z:   r_span[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // axis lanes
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        jan_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (w_accept),
            .i_raw    (w_raw[g]),
            .i_offset (r_offset[g]),
            .i_span   (r_span[g]),
            .o_busy   (w_busy[g]),
            .o_axis   (w_axis[g])
        );
    end

    // button debounce
    jan_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (w_accept),
        .i_pin     (i_button_pin),
        .i_tick    (i_debounce_tick),
        .o_pressed (w_pressed)
    );

    // merge: all lanes done and output register free or draining
    assign w_lanes_busy = |w_busy;
    assign w_load = (r_state == S_RUN) && !w_lanes_busy
                    && (!r_out_valid || i_out_ready);

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_axis[a] <= '0;
            end
            r_pressed   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_axis[a] <= w_axis[a];
                end
                r_pressed   <= w_pressed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_axis_x         = r_axis[0];
    assign o_axis_y         = r_axis[1];
    assign o_axis_z         = r_axis[2];
    assign o_button_pressed = r_pressed;

endmodule

/* src/jan_checker.sv */
// ----------------------------------------------------------------------------
// jan_checker
// Port-level checks of the joystick axis normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module jan_checker
    import jan_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] o_axis_x,
    input logic signed [OUT_W-1:0] o_axis_y,
    input logic signed [OUT_W-1:0] o_axis_z
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // one request at a time through the lanes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while lanes busy");

    // normalized axes stay within full scale
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_axis_x <= FULL_SCALE && o_axis_x >= -FULL_SCALE
                      && o_axis_y <= FULL_SCALE && o_axis_y >= -FULL_SCALE
                      && o_axis_z <= FULL_SCALE && o_axis_z >= -FULL_SCALE))
        else $error("axis outside full scale");

endmodule

bind joystick_axis_normalizer_unit jan_checker u_jan_checker (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for joystick_axis_normalizer_unit. Directed samples hit
// the axis extremes, zero and tiny spans, truncation and the debounce and
// press-latch paths. Random phases follow, each with its own calibration,
// under random idle bursts on both channels. Every result is compared with a
// prediction made when the request is accepted.
// ----------------------------------------------------------------------------
module tb
    import jan_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAW_W           = SAMPLE_BITS_DEF;
    localparam int SPAN_W          = 2 * RAW_W;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int TAIL_ITEMS      = 60;
    localparam int DRAIN_CYCLES    = 24;
    localparam int STALL_LIMIT     = 2000;

    // index past the last register, writes there are dropped
    localparam t_cfg_idx CFG_UNUSED = 3'd7;

    // one expected normalized sample
    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    pressed;
    } t_deflection;

    // predicts deflections and press pulses, holds them until they come out
    class axis_scoreboard;
        logic [RAW_W-1:0]  offset [3];
        logic [SPAN_W-1:0] span [3];
        logic              prev_pin;
        logic              level;
        logic              latch;
        t_deflection       pending[$];
        int                failures;

        function new();
            for (int a = 0; a < 3; a++) begin
                offset[a] = RAW_W'(512);
                span[a]   = SPAN_W'(524800);
            end
            prev_pin = 1'b1;
            level    = 1'b0;
            latch    = 1'b0;
            failures = 0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [SPAN_W-1:0] data);
            unique case (idx)
                CFG_OFFSET_X: offset[0] = data[RAW_W-1:0];
                CFG_OFFSET_Y: offset[1] = data[RAW_W-1:0];
                CFG_OFFSET_Z: offset[2] = data[RAW_W-1:0];
                CFG_SPAN_X:   span[0] = data;
                CFG_SPAN_Y:   span[1] = data;
                CFG_SPAN_Z:   span[2] = data;
                default: ;
            endcase
        endfunction

        // offset removal, side-dependent scaling, saturation and clamp
        function logic signed [OUT_W-1:0] scale_axis(logic [RAW_W-1:0] raw, int a);
            int diff;
            int pos_span;
            int neg_span;
            int q;
            diff     = int'(raw) - int'(offset[a]);
            pos_span = int'(span[a][RAW_W-1:0]);
            neg_span = int'(span[a][SPAN_W-1:RAW_W]);
            if (diff > 0) begin
                q = (pos_span == 0) ? FULL_SCALE : (diff * FULL_SCALE) / pos_span;
            end else if (diff < 0) begin
                q = (neg_span == 0) ? -FULL_SCALE : (diff * FULL_SCALE) / neg_span;
            end else begin
                q = 0;
            end
            if (q > FULL_SCALE) q = FULL_SCALE;
            if (q < -FULL_SCALE) q = -FULL_SCALE;
            return OUT_W'(q);
        endfunction

        function void note_sample(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                                  logic [RAW_W-1:0] rz, logic pin, logic tick);
            t_deflection d;
            d.x = scale_axis(rx, 0);
            d.y = scale_axis(ry, 1);
            d.z = scale_axis(rz, 2);
            // debounce: level moves only when two ticked samples agree
            if (tick) begin
                if (pin == prev_pin) level = ~pin;
                prev_pin = pin;
            end
            // one pulse per press
            d.pressed = 1'b0;
            if (level && !latch) begin
                latch     = 1'b1;
                d.pressed = 1'b1;
            end else if (!level && latch) begin
                latch = 1'b0;
            end
            pending.push_back(d);
        endfunction

        function void check_result(logic signed [OUT_W-1:0] ax, logic signed [OUT_W-1:0] ay,
                                   logic signed [OUT_W-1:0] az, logic pressed);
            t_deflection d;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            d = pending.pop_front();
            if (ax !== d.x) begin
                $error("axis_x expected %0d got %0d", d.x, ax);
                failures++;
            end
            if (ay !== d.y) begin
                $error("axis_y expected %0d got %0d", d.y, ay);
                failures++;
            end
            if (az !== d.z) begin
                $error("axis_z expected %0d got %0d", d.z, az);
                failures++;
            end
            if (pressed !== d.pressed) begin
                $error("button_pressed expected %0b got %0b", d.pressed, pressed);
                failures++;
            end
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    t_cfg_idx                cfg_index = CFG_OFFSET_X;
    logic [SPAN_W-1:0]       cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [RAW_W-1:0]        raw_x     = '0;
    logic [RAW_W-1:0]        raw_y     = '0;
    logic [RAW_W-1:0]        raw_z     = '0;
    logic                    button_pin    = 1'b1;
    logic                    debounce_tick = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] axis_x;
    logic signed [OUT_W-1:0] axis_y;
    logic signed [OUT_W-1:0] axis_z;
    logic                    button_pressed;

    axis_scoreboard sb = new();

    int   gap_odds   = 3;
    int   stall_odds = 3;
    int   stall_left = 0;
    bit   quiet_tail = 1'b0;
    int   idle_count = 0;
    logic held_pin   = 1'b1;

    joystick_axis_normalizer_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_raw_x          (raw_x),
        .i_raw_y          (raw_y),
        .i_raw_z          (raw_z),
        .i_button_pin     (button_pin),
        .i_debounce_tick  (debounce_tick),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_axis_x         (axis_x),
        .o_axis_y         (axis_y),
        .o_axis_z         (axis_z),
        .o_button_pressed (button_pressed)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stalls in random bursts
    always @(negedge clk) begin
        if (stall_left > 0 && !quiet_tail) begin
            stall_left--;
            out_ready = 1'b0;
        end else if (!quiet_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(1, 19) - 1;
            out_ready  = 1'b0;
        end else begin
            out_ready = 1'b1;
        end
    end

    // result check
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(axis_x, axis_y, axis_z, button_pressed);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic write_register(input t_cfg_idx idx, input logic [SPAN_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                               input logic [RAW_W-1:0] rz, input logic pin,
                               input logic tick);
        @(negedge clk);
        raw_x         = rx;
        raw_y         = ry;
        raw_z         = rz;
        button_pin    = pin;
        debounce_tick = tick;
        in_valid      = 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(rx, ry, rz, pin, tick);
    endtask

    // sender gap of random length, taken at random
    task automatic maybe_pause();
        int n;
        if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            n = $urandom_range(1, 19);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // block idle: all results back, then the latency margin
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mode 0 lowest, 1 highest, else biased random
    function automatic logic [SPAN_W-1:0] pick_offset(int mode);
        logic [RAW_W-1:0] v;
        case (mode)
            0: v = '0;
            1: v = '1;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = '1;
                    2: v = RAW_W'(512);
                    default: v = RAW_W'($urandom);
                endcase
            end
        endcase
        // upper bits are junk the register must drop
        return {RAW_W'($urandom), v};
    endfunction

    function automatic logic [RAW_W-1:0] pick_span_half();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RAW_W'(1);
            2: return '1;
            3: return RAW_W'($urandom_range(1, 31));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [SPAN_W-1:0] pick_span(int mode);
        case (mode)
            0: return '0;
            1: return '1;
            default: return {pick_span_half(), pick_span_half()};
        endcase
    endfunction

    task automatic load_calibration(input int mode);
        write_register(CFG_OFFSET_X, pick_offset(mode));
        write_register(CFG_OFFSET_Y, pick_offset(mode));
        write_register(CFG_OFFSET_Z, pick_offset(mode));
        write_register(CFG_SPAN_X, pick_span(mode));
        write_register(CFG_SPAN_Y, pick_span(mode));
        write_register(CFG_SPAN_Z, pick_span(mode));
    endtask

    // random sample: axes sometimes close to rest, pin mostly steady
    task automatic send_random_sample();
        logic [RAW_W-1:0] r [3];
        logic             pin;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 3) == 0) begin
                r[a] = sb.offset[a] + RAW_W'($urandom_range(0, 16)) - RAW_W'(8);
            end else begin
                r[a] = RAW_W'($urandom);
            end
        end
        if ($urandom_range(0, 11) == 0) held_pin = ~held_pin;
        pin = held_pin ^ ($urandom_range(0, 7) == 0);
        send_sample(r[0], r[1], r[2], pin, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int mode;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset calibration: rest, full swings, truncation, debounce and latch
        send_sample(10'd512, 10'd512, 10'd512, 1'b1, 1'b0);
        send_sample(10'd1023, 10'd0, 10'd513, 1'b0, 1'b1);
        send_sample(10'd0, 10'd1023, 10'd511, 1'b0, 1'b1);
        send_sample(10'd513, 10'd511, 10'd1023, 1'b0, 1'b1);
        send_sample(10'd0, 10'd0, 10'd0, 1'b1, 1'b0);
        maybe_pause();
        send_sample(10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1);
        send_sample(10'd600, 10'd400, 10'd700, 1'b1, 1'b1);
        send_sample(10'd1, 10'd2, 10'd4, 1'b0, 1'b0);
        send_sample(10'd8, 10'd16, 10'd32, 1'b0, 1'b1);
        maybe_pause();
        send_sample(10'd64, 10'd128, 10'd256, 1'b1, 1'b1);
        send_sample(10'd682, 10'd341, 10'd1022, 1'b0, 1'b1);
        send_sample(10'd5, 10'd5, 10'd5, 1'b0, 1'b1);

        // zero spans, one-count spans, full spans, offsets at the ends
        settle();
        write_register(CFG_OFFSET_X, {10'h3ff, 10'd512});
        write_register(CFG_OFFSET_Y, 20'd1023);
        write_register(CFG_OFFSET_Z, 20'd0);
        write_register(CFG_SPAN_X, 20'd0);
        write_register(CFG_SPAN_Y, {10'd1, 10'd1});
        write_register(CFG_SPAN_Z, {10'd1023, 10'd1023});
        write_register(CFG_UNUSED, 20'hfffff);
        send_sample(10'd1023, 10'd0, 10'd1023, 1'b1, 1'b1);
        send_sample(10'd0, 10'd1022, 10'd8, 1'b1, 1'b1);
        send_sample(10'd512, 10'd1023, 10'd0, 1'b0, 1'b0);
        send_sample(10'd700, 10'd1000, 10'd500, 1'b1, 1'b0);
        send_sample(10'd300, 10'd1023, 10'd1, 1'b0, 1'b0);

        // random phases: all-low and all-high calibration at the ends
        for (int p = 0; p < PHASES; p++) begin
            settle();
            mode = (p == 0) ? 0 : (p == PHASES - 1) ? 1 : 2;
            load_calibration(mode);
            gap_odds   = 3 * $urandom_range(0, 2);
            stall_odds = 3 * $urandom_range(0, 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == PHASES - 1 && n >= ITEMS_PER_PHASE - TAIL_ITEMS) quiet_tail = 1'b1;
                maybe_pause();
                send_random_sample();
            end
        end

        settle();
        if (sb.pending.size() != 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
